FILE: rtl/sha256_message_hasher_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 message hasher assertion macros
// Concurrent assertion shorthands, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SHA256_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SHA256_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Widths, round constants, initial hash value, sequencer states and the
// SHA-256 bit-mixing functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int WORD_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 3;
   localparam int COUNT_W = 61;

   localparam logic [7:0] PAD_MARKER = 8'h80;

   // Round constants
   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Initial hash value
   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ROUND = 5'b00010,
      S_FOLD  = 5'b00100,
      S_PAD   = 5'b01000,
      S_OUT   = 5'b10000
   } sha256_state_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

FILE: rtl/sha256_req_if.sv
// ----------------------------------------------------------------------------
// SHA-256 request channel
// Valid/ready channel carrying one message byte and its framing flags.
// ----------------------------------------------------------------------------
interface sha256_req_if
   import sha256_pkg::*;
   ();

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              has_byte;
   logic              is_last;

   modport source (output valid, output data_byte, output has_byte, output is_last,
                   input ready);
   modport sink   (input valid, input data_byte, input has_byte, input is_last,
                   output ready);

endinterface

FILE: rtl/sha256_rsp_if.sv
// ----------------------------------------------------------------------------
// SHA-256 response channel
// Valid/ready channel carrying one digest word with its position.
// ----------------------------------------------------------------------------
interface sha256_rsp_if
   import sha256_pkg::*;
   ();

   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  digest_word;
   logic [INDEX_W-1:0] word_index;
   logic               last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink   (input valid, input digest_word, input word_index, input last_word,
                   output ready);

endinterface

FILE: rtl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Packs a byte stream into 512-bit blocks, compresses each with one round
// per cycle on a shared round unit, pads the message and streams the digest.
// ----------------------------------------------------------------------------
//  channel   direction  beat
//  req_bus   in         one message byte, has_byte and is_last flags
//  rsp_bus   out        one digest word, its index and a last-word flag
//
//  A byte that does not fill a block is simply shifted in; a byte that fills one
//  is followed by 64 rounds and a fold before req_bus is ready again.
//  End of message: padding bytes up to the block end, 64 rounds and a fold
//  per padded block (one or two), then 8 digest beats at rsp_bus pace.
//  Reset is synchronous and loads the initial hash value; no clearing pass.
//  req_bus is ready only while idle; rsp_bus stalls hold the current word.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_macros.svh"

module sha256_message_hasher
   import sha256_pkg::*;
   (
   input logic         clock,
   input logic         reset,
   sha256_req_if.sink   req_bus,
   sha256_rsp_if.source rsp_bus
   );

   sha256_state_type   state_ff, state_in;
   logic [5:0]         pos_ff, pos_in;
   logic [COUNT_W-1:0] msg_ff, msg_in;
   logic [5:0]         round_ff, round_in;
   logic [INDEX_W-1:0] out_idx_ff, out_idx_in;
   logic               pad_mode_ff, pad_mode_in;
   logic               pad_first_ff, pad_first_in;
   logic               len_block_ff, len_block_in;
   logic               pend_last_ff, pend_last_in;
   logic [31:0]        chain_ff [8];
   logic [31:0]        chain_in [8];
   logic [31:0]        work_ff [8];
   logic [31:0]        work_in [8];
   logic [31:0]        win_ff [16];
   logic [31:0]        win_in [16];

   logic               req_beat;
   logic               rsp_beat;
   logic [5:0]         pos_inc;
   logic [5:0]         pos_after;
   logic [63:0]        bit_len;
   logic [7:0]         len_byte;
   logic [7:0]         pad_byte;
   logic [7:0]         shift_byte;
   logic               shift_en;
   logic               load_work;
   logic [31:0]        sched_w;
   logic [31:0]        round_w;
   logic [31:0]        t1;
   logic [31:0]        t2;

   assign req_beat  = req_bus.valid & req_bus.ready;
   assign rsp_beat  = rsp_bus.valid & rsp_bus.ready;
   assign pos_inc   = pos_ff + 6'd1;
   assign pos_after = req_bus.has_byte ? pos_inc : pos_ff;

   // Pick the padding byte: marker, zero fill, or the big-endian bit length
   assign bit_len  = {msg_ff, 3'b000};
   assign len_byte = bit_len[{3'd7 - pos_ff[2:0], 3'b000} +: 8];
   always_comb begin
      if (pad_first_ff) begin
         pad_byte = PAD_MARKER;
      end else if (len_block_ff && (pos_ff >= 6'd56)) begin
         pad_byte = len_byte;
      end else begin
         pad_byte = '0;
      end
   end

   // Round unit: message schedule word and the two temporaries
   assign sched_w = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
   assign round_w = (round_ff < 6'd16) ? win_ff[0] : sched_w;
   assign t1 = work_ff[7] + big_sigma1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + ROUND_K[round_ff] + round_w;
   assign t2 = big_sigma0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]));

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      msg_in       = msg_ff;
      round_in     = round_ff;
      out_idx_in   = out_idx_ff;
      pad_mode_in  = pad_mode_ff;
      pad_first_in = pad_first_ff;
      len_block_in = len_block_ff;
      pend_last_in = pend_last_ff;
      chain_in     = chain_ff;
      shift_byte   = req_bus.data_byte;
      shift_en     = 1'b0;
      load_work    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               if (req_bus.has_byte) begin
                  shift_en = 1'b1;
                  pos_in   = pos_inc;
                  msg_in   = msg_ff + COUNT_W'(1);
               end
               if (req_bus.has_byte && (pos_ff == 6'd63)) begin
                  // Block full: compress first, pad afterwards if last
                  state_in     = S_ROUND;
                  round_in     = '0;
                  load_work    = 1'b1;
                  pend_last_in = req_bus.is_last;
               end else if (req_bus.is_last) begin
                  state_in     = S_PAD;
                  pad_mode_in  = 1'b1;
                  pad_first_in = 1'b1;
                  len_block_in = (pos_after < 6'd56);
               end
            end
         end
         S_PAD: begin
            shift_byte   = pad_byte;
            shift_en     = 1'b1;
            pos_in       = pos_inc;
            pad_first_in = 1'b0;
            if (pos_ff == 6'd63) begin
               state_in  = S_ROUND;
               round_in  = '0;
               load_work = 1'b1;
            end
         end
         S_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            if (pad_mode_ff) begin
               if (len_block_ff) begin
                  state_in   = S_OUT;
                  out_idx_in = '0;
               end else begin
                  // Marker block done: one more block carries the length
                  state_in     = S_PAD;
                  len_block_in = 1'b1;
               end
            end else if (pend_last_ff) begin
               state_in     = S_PAD;
               pad_mode_in  = 1'b1;
               pad_first_in = 1'b1;
               len_block_in = 1'b1;
               pend_last_in = 1'b0;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            if (rsp_beat) begin
               out_idx_in = out_idx_ff + INDEX_W'(1);
               if (out_idx_ff == INDEX_W'(7)) begin
                  // Digest sent: reload for the next message
                  state_in    = S_IDLE;
                  chain_in    = INIT_HASH;
                  pos_in      = '0;
                  msg_in      = '0;
                  pad_mode_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Block window: byte shift while loading, word shift while compressing
   always_comb begin
      win_in  = win_ff;
      work_in = work_ff;
      if (shift_en) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = {win_ff[i][23:0], win_ff[i+1][31:24]};
         end
         win_in[15] = {win_ff[15][23:0], shift_byte};
      end else if (state_ff == S_ROUND) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[15] = round_w;
      end
      if (load_work) begin
         work_in = chain_ff;
      end else if (state_ff == S_ROUND) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end
   end

   // Control and chaining registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         msg_ff       <= '0;
         round_ff     <= '0;
         out_idx_ff   <= '0;
         pad_mode_ff  <= 1'b0;
         pad_first_ff <= 1'b0;
         len_block_ff <= 1'b0;
         pend_last_ff <= 1'b0;
         chain_ff     <= INIT_HASH;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         msg_ff       <= msg_in;
         round_ff     <= round_in;
         out_idx_ff   <= out_idx_in;
         pad_mode_ff  <= pad_mode_in;
         pad_first_ff <= pad_first_in;
         len_block_ff <= len_block_in;
         pend_last_ff <= pend_last_in;
         chain_ff     <= chain_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      work_ff <= work_in;
   end

   // Drive the channels
   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = (state_ff == S_OUT);
   assign rsp_bus.digest_word = chain_ff[out_idx_ff];
   assign rsp_bus.word_index  = out_idx_ff;
   assign rsp_bus.last_word   = (out_idx_ff == INDEX_W'(7));

   // Checks
   `SHA256_ASSERT_SAME(a_out_block_aligned, rsp_bus.valid, pos_ff == 6'd0,
                       "digest sent with bytes left in block")
   `SHA256_ASSERT_NEXT(a_round_end_folds, (state_ff == S_ROUND) && (round_ff == 6'd63),
                       state_ff == S_FOLD, "last round not followed by fold")
   `SHA256_ASSERT_NEXT(a_digest_reloads, rsp_beat && rsp_bus.last_word,
                       (msg_ff == '0) && (chain_ff[0] == INIT_HASH[0]),
                       "hash state not reloaded after digest")
   `SHA256_ASSERT_NEXT(a_marker_once, (state_ff == S_PAD) && pad_first_ff, !pad_first_ff,
                       "padding marker inserted twice")

endmodule
